// ===== rtl/dmx_stream_receive_filter_macros.svh =====
// assertion macros for the dmx stream receive filter checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef DMX_STREAM_RECEIVE_FILTER_MACROS_SVH
`define DMX_STREAM_RECEIVE_FILTER_MACROS_SVH

// checked only while out of reset
`define DMXRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define DMXRF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/dmxrf_pkg.sv =====
// types, codes and constants of the dmx stream receive filter
// no dependencies
package dmxrf_pkg;

    localparam logic [2:0] REQ_E131_DATA   = 3'd0;
    localparam logic [2:0] REQ_E131_SYNC   = 3'd1;
    localparam logic [2:0] REQ_ARTNET_DMX  = 3'd2;
    localparam logic [2:0] REQ_ARTNET_SYNC = 3'd3;
    localparam logic [2:0] REQ_ARTNET_POLL = 3'd4;
    localparam logic [2:0] REQ_SYNC_TMO    = 3'd5;
    localparam logic [2:0] REQ_STREAM_END  = 3'd6;

    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_SHOW_NOW    = 3'd1;
    localparam logic [2:0] ACT_HOLD_SYNC   = 3'd2;
    localparam logic [2:0] ACT_SHOW_HELD   = 3'd3;
    localparam logic [2:0] ACT_BLANK       = 3'd4;
    localparam logic [2:0] ACT_POLL_REPLY  = 3'd5;
    localparam logic [2:0] ACT_END_IGNORED = 3'd6;

    localparam logic [1:0] CFG_OWN_UNIVERSE  = 2'd0;
    localparam logic [1:0] CFG_ARTNET_NET    = 2'd1;
    localparam logic [1:0] CFG_ARTNET_SUBNET = 2'd2;

    localparam logic [7:0]  OPT_PREVIEW    = 8'h80;
    localparam logic [7:0]  OPT_TERMINATED = 8'h40;
    localparam logic [7:0]  OPT_FORCE_SYNC = 8'h20;
    localparam logic [15:0] E131_UNI_MAX   = 16'd63999;
    localparam logic [7:0]  E131_PRIO_MAX  = 8'd200;
    localparam logic [9:0]  E131_CNT_MAX   = 10'd513;
    localparam logic [9:0]  DMX_CNT_MIN    = 10'd384;
    localparam logic [9:0]  ARTNET_CNT_MAX = 10'd512;
    localparam logic signed [7:0] SEQ_STALE_LIMIT = -8'sd20;

    typedef struct packed {
        logic [2:0]  req_type;
        logic        header_ok;
        logic [7:0]  sequence_req;
        logic [15:0] universe;
        logic [7:0]  priority_req;
        logic [7:0]  options;
        logic [63:0] cid_high;
        logic [63:0] cid_low;
        logic [15:0] sync_address;
        logic [9:0]  value_count;
        logic [31:0] source_ip;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  action;
        logic        join_sync_group;
        logic        leave_sync_group;
        logic [15:0] group_address;
        logic        restart_data_timer;
        logic        restart_sync_timer;
        logic        restart_artnet_sync_timer;
    } t_out_word;

    typedef struct packed {
        logic [7:0] own_universe;
        logic [6:0] artnet_net;
        logic [3:0] artnet_subnet;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{own_universe: 8'd1, artnet_net: 7'd0, artnet_subnet: 4'd0};

    typedef struct packed {
        logic [63:0] source_cid_high;
        logic [63:0] source_cid_low;
        logic [31:0] last_source;
        logic [15:0] sync_universe;
        logic [7:0]  data_seq;
        logic [7:0]  sync_seq;
        logic [7:0]  source_priority;
        logic        synced;
        logic        force_sync;
    } t_state;

    // stale when packet minus held, as signed 8 bit, lies in -19..0
    function automatic logic seq_stale(input logic [7:0] pkt, input logic [7:0] held);
        logic [7:0] d;
        d = pkt - held;
        return (d == 8'd0) || (d[7] && ($signed(d) > SEQ_STALE_LIMIT));
    endfunction

endpackage

// ===== rtl/dmxrf_decide.sv =====
// per-word filter decision: next stream state and the result word
// depends on dmxrf_pkg
module dmxrf_decide (
    input  dmxrf_pkg::t_in_word  i_item,
    input  dmxrf_pkg::t_state    i_state,
    input  dmxrf_pkg::t_cfg      i_cfg,
    output dmxrf_pkg::t_state    o_state,
    output dmxrf_pkg::t_out_word o_result
);
    import dmxrf_pkg::*;

    always_comb begin
        logic       term;
        logic       force_req;
        logic       cid_diff;
        logic       reject;
        logic       mismatch;
        logic       ok;
        logic       end_req;
        logic [7:0] want_sub;

        o_state  = i_state;
        o_result = '0;
        end_req  = 1'b0;
        ok       = 1'b0;

        term      = (i_item.options & OPT_TERMINATED) != 8'd0;
        force_req = (i_item.options & OPT_FORCE_SYNC) != 8'd0;
        cid_diff  = (i_item.cid_high != i_state.source_cid_high)
                 || (i_item.cid_low != i_state.source_cid_low);
        reject = ((i_state.data_seq != 8'd0) && seq_stale(i_item.sequence_req, i_state.data_seq))
              || (i_item.universe == 16'd0) || (i_item.universe > E131_UNI_MAX)
              || (i_item.priority_req > E131_PRIO_MAX)
              || (i_item.priority_req < i_state.source_priority)
              || ((i_state.data_seq != 8'd0) && cid_diff
                  && (i_item.priority_req == i_state.source_priority))
              || ((i_item.options & OPT_PREVIEW) != 8'd0) || term
              || ((i_state.sync_universe != 16'd0) && !force_req && !i_state.synced)
              || (i_item.value_count > E131_CNT_MAX) || (i_item.value_count < DMX_CNT_MIN);
        mismatch = (i_state.sync_universe != 16'd0) && (i_item.sync_address != 16'd0)
                && (i_state.sync_universe != i_item.sync_address);
        want_sub = {i_cfg.artnet_subnet, 4'd0} | i_cfg.own_universe;

        case (i_item.req_type)
            REQ_E131_DATA: begin
                if (i_item.header_ok) begin
                    if (reject) begin
                        end_req = term;
                    end else begin
                        o_state.source_cid_high = i_item.cid_high;
                        o_state.source_cid_low  = i_item.cid_low;
                        o_state.source_priority = i_item.priority_req;
                        o_state.force_sync      = force_req;
                        o_state.data_seq        = i_item.sequence_req;
                        if (!mismatch) begin
                            if (i_state.sync_universe == 16'd0 && i_item.sync_address != 16'd0) begin
                                if (i_item.sync_address[15:8] != 8'd0
                                    || i_item.sync_address[7:0] != i_cfg.own_universe) begin
                                    o_result.join_sync_group = 1'b1;
                                    o_result.group_address   = i_item.sync_address;
                                end
                                o_state.synced = 1'b0;
                            end else if (i_state.sync_universe != 16'd0
                                         && i_item.sync_address == 16'd0) begin
                                o_state.synced = 1'b0;
                                o_result.leave_sync_group = 1'b1;
                            end
                            o_state.sync_universe = i_item.sync_address;
                            o_result.action = (i_item.sync_address == 16'd0) ? ACT_SHOW_NOW
                                                                             : ACT_HOLD_SYNC;
                            o_result.restart_data_timer = 1'b1;
                        end
                    end
                end
            end
            REQ_E131_SYNC: begin
                if (i_item.header_ok
                    && !((i_state.sync_seq != 8'd0)
                         && seq_stale(i_item.sequence_req, i_state.sync_seq))
                    && i_item.sync_address != 16'd0
                    && i_item.sync_address == i_state.sync_universe) begin
                    o_state.sync_seq = i_item.sequence_req;
                    o_state.synced   = 1'b1;
                    o_result.action  = ACT_SHOW_HELD;
                    o_result.restart_sync_timer = 1'b1;
                end
            end
            REQ_ARTNET_DMX: begin
                if (i_item.header_ok) begin
                    ok = 1'b1;
                    if (i_item.sequence_req != 8'd0) begin
                        if (seq_stale(i_item.sequence_req, i_state.data_seq)) begin
                            ok = 1'b0;
                        end else begin
                            o_state.data_seq = i_item.sequence_req;
                        end
                    end
                    if (i_item.universe[14:8] != i_cfg.artnet_net
                        || i_item.universe[7:0] != want_sub
                        || i_item.value_count < DMX_CNT_MIN
                        || i_item.value_count > ARTNET_CNT_MAX
                        || (i_state.last_source[31:24] != 8'd0
                            && i_state.last_source != i_item.source_ip)) begin
                        ok = 1'b0;
                    end
                    if (ok) begin
                        o_state.last_source = i_item.source_ip;
                        o_result.action = i_state.synced ? ACT_HOLD_SYNC : ACT_SHOW_NOW;
                        o_result.restart_data_timer = 1'b1;
                    end
                end
            end
            REQ_ARTNET_SYNC: begin
                if (i_item.header_ok && i_state.last_source == i_item.source_ip) begin
                    o_state.synced  = 1'b1;
                    o_result.action = ACT_SHOW_HELD;
                    o_result.restart_artnet_sync_timer = 1'b1;
                end
            end
            REQ_ARTNET_POLL: begin
                if (i_item.header_ok) begin
                    o_result.action = ACT_POLL_REPLY;
                end
            end
            REQ_SYNC_TMO: begin
                o_state.synced = 1'b0;
            end
            REQ_STREAM_END: begin
                end_req = 1'b1;
            end
            default: begin
            end
        endcase

        if (end_req) begin
            if (i_state.sync_universe != 16'd0 && !i_state.force_sync) begin
                o_result.action = ACT_END_IGNORED;
            end else begin
                o_state  = '0;
                o_result = '0;
                o_result.action = ACT_BLANK;
                o_result.leave_sync_group = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dmx_stream_receive_filter.sv =====
// dmx stream receive filter top level: input register, stream state, result register
// depends on dmxrf_pkg and dmxrf_decide
//
// channel | direction | handshake              | payload
// in      | in        | i_in_valid/o_in_ready   | i_in_data (t_in_word)
// out     | out       | o_out_valid/i_out_ready | o_out_data (t_out_word)
// cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// one word per cycle unless the output stalls; a word waits in the input register
// and its result in the result register; the decision runs between the two
// a stalled result register holds the input register, which still takes a word while empty
// synchronous reset restores the registers and clears the stream state
// cfg writes are taken every cycle
module dmx_stream_receive_filter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  dmxrf_pkg::t_in_word       i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output dmxrf_pkg::t_out_word      o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [7:0]                i_cfg_data
);
    import dmxrf_pkg::*;

    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    logic      r_out_valid;
    t_state    r_state;
    t_state    n_state;
    t_out_word n_out;
    t_cfg      r_cfg;
    logic      w_advance;

    assign w_advance   = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    dmxrf_decide u_decide (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_cfg       <= CFG_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && w_advance) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OWN_UNIVERSE:  r_cfg.own_universe  <= i_cfg_data;
                    CFG_ARTNET_NET:    r_cfg.artnet_net    <= i_cfg_data[6:0];
                    CFG_ARTNET_SUBNET: r_cfg.artnet_subnet <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (r_in_valid && w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/dmxrf_checker.sv =====
// port-level checks for the dmx stream receive filter, bound to the top level
// depends on dmxrf_pkg and dmx_stream_receive_filter_macros.svh
`include "dmx_stream_receive_filter_macros.svh"

module dmxrf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input dmxrf_pkg::t_out_word o_out_data
);
    import dmxrf_pkg::*;

    `DMXRF_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid,
        "result valid after reset")
    `DMXRF_ASSERT(a_out_hold,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data),
        "stalled result changed")
    `DMXRF_ASSERT(a_group_zero,
        o_out_valid && !o_out_data.join_sync_group |-> o_out_data.group_address == 16'd0,
        "group address without join")
    `DMXRF_ASSERT(a_join_leave,
        o_out_valid |-> !(o_out_data.join_sync_group && o_out_data.leave_sync_group),
        "join and leave together")
    `DMXRF_ASSERT(a_data_timer,
        o_out_valid && o_out_data.restart_data_timer
            |-> o_out_data.action == ACT_SHOW_NOW || o_out_data.action == ACT_HOLD_SYNC,
        "data timer restart without display")

endmodule

bind dmx_stream_receive_filter dmxrf_checker u_dmxrf_checker (.*);

// ===== verif/tb.sv =====
// self-checking testbench for dmx_stream_receive_filter: directed and random packet summaries
// with random stalls on both channels, results checked against an in-bench prediction
// depends on dmxrf_pkg and the dmx_stream_receive_filter rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dmxrf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam logic [1:0] CFG_NO_REGISTER = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_OWN_UNIVERSE;
    logic [7:0] i_cfg_data = 8'd0;

    t_state      stream = '0;
    t_cfg        node_cfg = CFG_RESET;
    t_in_word    packets_to_send[$];
    t_out_word   actions_due[$];
    int unsigned packets_queued = 0;
    int unsigned packets_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;

    logic [63:0] cid_hi_pool[3];
    logic [63:0] cid_lo_pool[3];
    logic [31:0] ip_pool[3];
    logic [15:0] group_pool[4];
    logic [15:0] guessed_group;
    logic [7:0]  next_data_seq = 8'd0;
    logic [7:0]  next_sync_seq = 8'd0;

    dmx_stream_receive_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // packet minus held as signed 8 bit in -19..0
    function automatic logic seq_is_old(input logic [7:0] pkt, input logic [7:0] held);
        logic [7:0] diff;
        diff = pkt - held;
        return (diff == 8'd0) || (diff >= 8'd237);
    endfunction

    function automatic t_out_word close_stream(input t_out_word res);
        t_out_word r;
        r = res;
        if (stream.sync_universe != 16'd0 && !stream.force_sync) begin
            r.action = ACT_END_IGNORED;
        end else begin
            stream = '0;
            r.action = ACT_BLANK;
            r.leave_sync_group = 1'b1;
        end
        return r;
    endfunction

    function automatic t_out_word predict_action(input t_in_word w);
        t_out_word  res;
        logic       term;
        logic       force_bit;
        logic       cid_diff;
        logic       reject;
        logic       ok;
        logic [7:0] want_sub;
        res = '0;
        case (w.req_type)
            REQ_E131_DATA: begin
                if (w.header_ok) begin
                    term = (w.options & OPT_TERMINATED) != 8'd0;
                    force_bit = (w.options & OPT_FORCE_SYNC) != 8'd0;
                    cid_diff = (w.cid_high != stream.source_cid_high) ||
                               (w.cid_low != stream.source_cid_low);
                    reject = (stream.data_seq != 8'd0 &&
                              seq_is_old(w.sequence_req, stream.data_seq)) ||
                             w.universe == 16'd0 || w.universe > E131_UNI_MAX ||
                             w.priority_req > E131_PRIO_MAX ||
                             w.priority_req < stream.source_priority ||
                             (stream.data_seq != 8'd0 && cid_diff &&
                              w.priority_req == stream.source_priority) ||
                             (w.options & OPT_PREVIEW) != 8'd0 || term ||
                             (stream.sync_universe != 16'd0 && !force_bit && !stream.synced) ||
                             w.value_count > E131_CNT_MAX || w.value_count < DMX_CNT_MIN;
                    if (reject) begin
                        if (term) begin
                            res = close_stream(res);
                        end
                    end else begin
                        stream.source_cid_high = w.cid_high;
                        stream.source_cid_low = w.cid_low;
                        stream.source_priority = w.priority_req;
                        stream.force_sync = force_bit;
                        stream.data_seq = w.sequence_req;
                        if (!(stream.sync_universe != 16'd0 && w.sync_address != 16'd0 &&
                              stream.sync_universe != w.sync_address)) begin
                            if (stream.sync_universe == 16'd0 && w.sync_address != 16'd0) begin
                                if (w.sync_address[15:8] != 8'd0 ||
                                    w.sync_address[7:0] != node_cfg.own_universe) begin
                                    res.join_sync_group = 1'b1;
                                    res.group_address = w.sync_address;
                                end
                                stream.synced = 1'b0;
                            end else if (stream.sync_universe != 16'd0 &&
                                         w.sync_address == 16'd0) begin
                                stream.synced = 1'b0;
                                res.leave_sync_group = 1'b1;
                            end
                            stream.sync_universe = w.sync_address;
                            res.action = (stream.sync_universe == 16'd0) ? ACT_SHOW_NOW
                                                                         : ACT_HOLD_SYNC;
                            res.restart_data_timer = 1'b1;
                        end
                    end
                end
            end
            REQ_E131_SYNC: begin
                if (w.header_ok &&
                    !((stream.sync_seq != 8'd0 && seq_is_old(w.sequence_req, stream.sync_seq)) ||
                      w.sync_address == 16'd0 || w.sync_address != stream.sync_universe)) begin
                    stream.sync_seq = w.sequence_req;
                    stream.synced = 1'b1;
                    res.action = ACT_SHOW_HELD;
                    res.restart_sync_timer = 1'b1;
                end
            end
            REQ_ARTNET_DMX: begin
                if (w.header_ok) begin
                    ok = 1'b1;
                    if (w.sequence_req != 8'd0) begin
                        if (seq_is_old(w.sequence_req, stream.data_seq)) begin
                            ok = 1'b0;
                        end else begin
                            stream.data_seq = w.sequence_req;
                        end
                    end
                    want_sub = {node_cfg.artnet_subnet, 4'd0} | node_cfg.own_universe;
                    if (ok && (w.universe[14:8] != node_cfg.artnet_net ||
                               w.universe[7:0] != want_sub ||
                               w.value_count < DMX_CNT_MIN || w.value_count > ARTNET_CNT_MAX ||
                               (stream.last_source[31:24] != 8'd0 &&
                                stream.last_source != w.source_ip))) begin
                        ok = 1'b0;
                    end
                    if (ok) begin
                        stream.last_source = w.source_ip;
                        res.action = stream.synced ? ACT_HOLD_SYNC : ACT_SHOW_NOW;
                        res.restart_data_timer = 1'b1;
                    end
                end
            end
            REQ_ARTNET_SYNC: begin
                if (w.header_ok && stream.last_source == w.source_ip) begin
                    stream.synced = 1'b1;
                    res.action = ACT_SHOW_HELD;
                    res.restart_artnet_sync_timer = 1'b1;
                end
            end
            REQ_ARTNET_POLL: begin
                if (w.header_ok) begin
                    res.action = ACT_POLL_REPLY;
                end
            end
            REQ_SYNC_TMO: begin
                stream.synced = 1'b0;
            end
            REQ_STREAM_END: begin
                res = close_stream(res);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void refresh_pools();
        for (int k = 0; k < 3; k++) begin
            cid_hi_pool[k] = {$urandom, $urandom};
            cid_lo_pool[k] = {$urandom, $urandom};
        end
        ip_pool[0] = {8'h00, 24'($urandom)};
        ip_pool[1] = {8'($urandom_range(255, 1)), 24'($urandom)};
        ip_pool[2] = $urandom;
        group_pool[0] = {8'h00, 8'($urandom)};
        group_pool[1] = 16'($urandom);
        group_pool[2] = 16'($urandom_range(63999, 1));
        group_pool[3] = 16'hffff;
        guessed_group = 16'd0;
    endfunction

    function automatic t_in_word base_packet(input logic [2:0] req);
        t_in_word w;
        w = '0;
        w.req_type = req;
        w.header_ok = 1'b1;
        w.universe = {8'h00, node_cfg.own_universe};
        w.priority_req = 8'd100;
        w.cid_high = cid_hi_pool[0];
        w.cid_low = cid_lo_pool[0];
        w.value_count = 10'd512;
        w.source_ip = ip_pool[1];
        return w;
    endfunction

    // mostly well-formed packets of one source, some noise and broken fields
    function automatic t_in_word random_packet();
        t_in_word    w;
        logic [255:0] noise;
        logic [7:0]  want_sub;
        int unsigned roll;
        w = base_packet(REQ_E131_DATA);
        w.header_ok = ($urandom_range(99) >= 4);
        roll = $urandom_range(99);
        w.source_ip = roll < 70 ? ip_pool[1] : roll < 85 ? ip_pool[0] :
                      roll < 95 ? ip_pool[2] : 32'($urandom);
        roll = $urandom_range(99);
        if (roll < 3) begin
            noise = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            w = noise[$bits(t_in_word)-1:0];
        end else if (roll < 45) begin
            w.req_type = REQ_E131_DATA;
            if ($urandom_range(9) == 0) begin
                w.sequence_req = 8'($urandom);
            end else begin
                next_data_seq = next_data_seq + 8'd1;
                w.sequence_req = next_data_seq;
            end
            roll = $urandom_range(99);
            w.universe = roll < 94 ? 16'($urandom_range(63999, 1)) : roll < 96 ? 16'd0 :
                         roll < 98 ? 16'd64000 : 16'($urandom);
            roll = $urandom_range(99);
            w.priority_req = roll < 70 ? 8'd100 : roll < 80 ? 8'd150 : roll < 85 ? 8'd200 :
                             roll < 90 ? 8'd50 : 8'($urandom);
            roll = $urandom_range(99);
            w.options = roll < 60 ? 8'h00 : roll < 85 ? OPT_FORCE_SYNC : roll < 89 ? OPT_PREVIEW :
                        roll < 93 ? OPT_TERMINATED : 8'($urandom);
            roll = $urandom_range(99);
            w.value_count = roll < 60 ? 10'd512 : roll < 88 ? 10'($urandom_range(513, 384)) :
                            10'($urandom_range(1023, 0));
            roll = $urandom_range(99);
            w.sync_address = roll < 60 ? guessed_group : roll < 75 ? 16'd0 :
                             roll < 85 ? {8'h00, node_cfg.own_universe} :
                             roll < 95 ? group_pool[2'($urandom_range(3))] : 16'($urandom);
            guessed_group = w.sync_address;
            roll = $urandom_range(99);
            if (roll >= 95) begin
                w.cid_high = {$urandom, $urandom};
                w.cid_low = {$urandom, $urandom};
            end else if (roll >= 80) begin
                w.cid_high = cid_hi_pool[2'(1 + (roll & 1))];
                w.cid_low = cid_lo_pool[2'(1 + (roll & 1))];
            end
        end else if (roll < 62) begin
            w.req_type = REQ_E131_SYNC;
            if ($urandom_range(9) == 0) begin
                w.sequence_req = 8'($urandom);
            end else begin
                next_sync_seq = next_sync_seq + 8'd1;
                w.sequence_req = next_sync_seq;
            end
            roll = $urandom_range(99);
            w.sync_address = roll < 75 ? guessed_group : roll < 85 ? 16'd0 : 16'($urandom);
        end else if (roll < 78) begin
            w.req_type = REQ_ARTNET_DMX;
            want_sub = {node_cfg.artnet_subnet, 4'd0} | node_cfg.own_universe;
            roll = $urandom_range(99);
            w.universe = roll < 85 ? {1'($urandom), node_cfg.artnet_net, want_sub}
                                   : 16'($urandom);
            roll = $urandom_range(99);
            w.value_count = roll < 85 ? 10'($urandom_range(512, 384))
                                      : 10'($urandom_range(1023, 0));
            roll = $urandom_range(99);
            if (roll < 20) begin
                w.sequence_req = 8'd0;
            end else if (roll < 95) begin
                next_data_seq = next_data_seq + 8'd1;
                w.sequence_req = next_data_seq;
            end else begin
                w.sequence_req = 8'($urandom);
            end
        end else if (roll < 87) begin
            w.req_type = REQ_ARTNET_SYNC;
        end else if (roll < 90) begin
            w.req_type = REQ_ARTNET_POLL;
        end else if (roll < 94) begin
            w.req_type = REQ_SYNC_TMO;
        end else if (roll < 97) begin
            w.req_type = REQ_STREAM_END;
        end else begin
            w.req_type = REQ_UNUSED;
        end
        return w;
    endfunction

    task automatic queue_packet(input t_in_word w);
        packets_to_send.push_back(w);
        packets_queued++;
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_OWN_UNIVERSE:  node_cfg.own_universe = val;
            CFG_ARTNET_NET:    node_cfg.artnet_net = val[6:0];
            CFG_ARTNET_SUBNET: node_cfg.artnet_subnet = val[3:0];
            default: begin
            end
        endcase
    endtask

    // waits until every word is taken and answered
    task automatic drain();
        do @(posedge i_clk); while (packets_taken != packets_queued || actions_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] own, input logic [7:0] net, input logic [7:0] sub,
                             input int unsigned count, input bit calm);
        write_cfg(CFG_OWN_UNIVERSE, own);
        write_cfg(CFG_ARTNET_NET, net);
        write_cfg(CFG_ARTNET_SUBNET, sub);
        refresh_pools();
        quiet = calm;
        repeat (count) queue_packet(random_packet());
        drain();
        quiet = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                actions_due.push_back(predict_action(i_in_data));
                packets_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (packets_to_send.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= packets_to_send.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (actions_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = actions_due.pop_front();
                    check_field("action", 16'(want.action), 16'(o_out_data.action));
                    check_field("join_sync_group", 16'(want.join_sync_group),
                                16'(o_out_data.join_sync_group));
                    check_field("leave_sync_group", 16'(want.leave_sync_group),
                                16'(o_out_data.leave_sync_group));
                    check_field("group_address", want.group_address, o_out_data.group_address);
                    check_field("restart_data_timer", 16'(want.restart_data_timer),
                                16'(o_out_data.restart_data_timer));
                    check_field("restart_sync_timer", 16'(want.restart_sync_timer),
                                16'(o_out_data.restart_sync_timer));
                    check_field("restart_artnet_sync_timer", 16'(want.restart_artnet_sync_timer),
                                16'(o_out_data.restart_artnet_sync_timer));
                end
            end
            i_out_ready <= quiet || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, actions_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_in_word w;
        refresh_pools();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and ignored words
        queue_packet('0);
        queue_packet('1);
        queue_packet(base_packet(REQ_ARTNET_POLL));
        w = base_packet(REQ_E131_DATA);
        w.header_ok = 1'b0;
        w.options = OPT_TERMINATED;
        queue_packet(w);
        // sequence window: first, repeat, then exactly twenty back
        w = base_packet(REQ_E131_DATA);
        w.sequence_req = 8'd1;
        queue_packet(w);
        queue_packet(w);
        w.sequence_req = 8'd237;
        queue_packet(w);
        w.sequence_req = 8'd238;
        w.universe = 16'd64000;
        queue_packet(w);
        w.universe = 16'd1;
        w.value_count = 10'd383;
        queue_packet(w);
        w.value_count = 10'd512;
        w.options = OPT_PREVIEW;
        queue_packet(w);
        // other source at equal, then higher priority
        w.options = 8'h00;
        w.cid_high = cid_hi_pool[1];
        w.cid_low = cid_lo_pool[1];
        queue_packet(w);
        w.sequence_req = 8'd239;
        w.priority_req = 8'd150;
        w.universe = 16'd63999;
        w.value_count = 10'd513;
        queue_packet(w);
        // own universe as sync group, sync, leave, foreign group, mismatch
        w.sequence_req = 8'd240;
        w.sync_address = {8'h00, node_cfg.own_universe};
        queue_packet(w);
        w = base_packet(REQ_E131_SYNC);
        w.sequence_req = 8'd5;
        w.sync_address = {8'h00, node_cfg.own_universe};
        queue_packet(w);
        w = base_packet(REQ_E131_DATA);
        w.cid_high = cid_hi_pool[1];
        w.cid_low = cid_lo_pool[1];
        w.priority_req = 8'd150;
        w.sequence_req = 8'd241;
        queue_packet(w);
        w.sequence_req = 8'd242;
        w.sync_address = 16'h0100;
        queue_packet(w);
        w.sequence_req = 8'd243;
        w.sync_address = 16'h0200;
        w.options = OPT_FORCE_SYNC;
        queue_packet(w);
        w = base_packet(REQ_E131_SYNC);
        w.sequence_req = 8'd5;
        w.sync_address = 16'h0100;
        queue_packet(w);
        w.sequence_req = 8'd6;
        queue_packet(w);
        queue_packet(base_packet(REQ_STREAM_END));
        // held group without force: end ignored, terminate path too
        w = base_packet(REQ_E131_DATA);
        w.sequence_req = 8'd1;
        w.sync_address = 16'h0100;
        queue_packet(w);
        queue_packet(base_packet(REQ_SYNC_TMO));
        w.sequence_req = 8'd2;
        w.options = OPT_TERMINATED;
        queue_packet(w);
        w = base_packet(REQ_STREAM_END);
        w.header_ok = 1'b0;
        queue_packet(w);
        // art-net frame with bit 15 set, sync from the same source, then a frame from another source
        w = base_packet(REQ_ARTNET_DMX);
        w.universe = {1'b1, node_cfg.artnet_net, node_cfg.own_universe};
        queue_packet(w);
        queue_packet(base_packet(REQ_ARTNET_SYNC));
        w.source_ip = ip_pool[2];
        w.value_count = 10'd513;
        queue_packet(w);
        drain();

        write_cfg(CFG_NO_REGISTER, 8'ha5);
        run_phase(8'h05, 8'hff, 8'hff, 250, 1'b0);
        run_phase(8'hff, 8'h00, 8'h00, 250, 1'b1);
        run_phase(8'h00, 8'h2a, 8'h05, 250, 1'b0);
        run_phase(8'h01, 8'h00, 8'h00, 250, 1'b0);

        if (mismatches == 0 && actions_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dmxrf_pkg.sv
rtl/dmxrf_decide.sv
rtl/dmx_stream_receive_filter.sv
rtl/dmxrf_checker.sv
verif/tb.sv
